// ===== hdl/pgnl_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the neighbour offset table for the grid lister.
// No dependencies.
package pgnl_pkg;

    localparam int ID_W               = 30;
    localparam int KIND_W             = 7;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 11;
    localparam int NUM_CAND           = 32;
    localparam int NUM_OFF            = 5;
    localparam int OFF_W              = 3;
    localparam int OFF_CENTER         = 2;
    localparam int KIND_Z_STRIDE      = 25;
    localparam int KIND_Y_STRIDE      = 5;
    localparam int AXIS_MAX_CELLS_DEF = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X = 3'd0,
        REG_SIZE_Y = 3'd1,
        REG_SIZE_Z = 3'd2,
        REG_WRAP_X = 3'd3,
        REG_WRAP_Y = 3'd4,
        REG_WRAP_Z = 3'd5
    } cfg_reg_t;

    // offset of one candidate, each field is offset + 2 (0..4)
    typedef struct packed {
        logic [OFF_W-1:0] iz;
        logic [OFF_W-1:0] iy;
        logic [OFF_W-1:0] ix;
    } off_t;

    // candidate order: cube with x outermost, centre skipped, then axial +-2
    function automatic off_t cand_off(input int p);
        off_t r;
        int   n;
        r = '0;
        n = 0;
        for (int a = 1; a <= 3; a++) begin
            for (int b = 1; b <= 3; b++) begin
                for (int c = 1; c <= 3; c++) begin
                    if (!(a == 2 && b == 2 && c == 2)) begin
                        if (n == p) begin
                            r.ix = OFF_W'(a);
                            r.iy = OFF_W'(b);
                            r.iz = OFF_W'(c);
                        end
                        n++;
                    end
                end
            end
        end
        case (p)
            26:      r = '{iz: 3'd2, iy: 3'd2, ix: 3'd0};
            27:      r = '{iz: 3'd2, iy: 3'd0, ix: 3'd2};
            28:      r = '{iz: 3'd0, iy: 3'd2, ix: 3'd2};
            29:      r = '{iz: 3'd2, iy: 3'd2, ix: 3'd4};
            30:      r = '{iz: 3'd2, iy: 3'd4, ix: 3'd2};
            31:      r = '{iz: 3'd4, iy: 3'd2, ix: 3'd2};
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [KIND_W-1:0] cand_kind(input int p);
        off_t o;
        o = cand_off(p);
        return KIND_W'(int'(o.iz) * KIND_Z_STRIDE + int'(o.iy) * KIND_Y_STRIDE
                       + int'(o.ix));
    endfunction

endpackage

// ===== hdl/pgnl_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for query and result beats.
// Depends on pgnl_pkg.
interface pgnl_query_if;
    import pgnl_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   cell_index;
    logic              final_query;

    modport source (output valid, output cell_index, output final_query, input ready);
    modport sink   (input valid, input cell_index, input final_query, output ready);
endinterface

interface pgnl_result_if;
    import pgnl_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   neighbour_index;
    logic [KIND_W-1:0] neighbour_kind;
    logic              cell_done;
    logic              list_done;

    modport source (output valid, output neighbour_index, output neighbour_kind,
                    output cell_done, output list_done, input ready);
    modport sink   (input valid, input neighbour_index, input neighbour_kind,
                    input cell_done, input list_done, output ready);
endinterface

// ===== hdl/pgnl_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with elastic stages.
// Depends on nothing beyond the clock domain; divisor must be nonzero and static.
module pgnl_div #(
    parameter int NUM_W  = 30,
    parameter int DEN_W  = 22,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [SIDE_W-1:0] in_side,
    input  logic [DEN_W-1:0]  den,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NUM_W-1:0]  out_quo,
    output logic [DEN_W-1:0]  out_rem,
    output logic [SIDE_W-1:0] out_side
);

    logic [NUM_W-1:0]  v_reg;
    logic [DEN_W-1:0]  a_reg [NUM_W];
    logic [NUM_W-1:0]  q_reg [NUM_W];
    logic [SIDE_W-1:0] s_reg [NUM_W];
    logic [NUM_W:0]    rdy;

    assign rdy[NUM_W] = out_ready;
    assign in_ready   = rdy[0];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic              pv;
        logic [DEN_W-1:0]  pa;
        logic [NUM_W-1:0]  pq;
        logic [SIDE_W-1:0] ps;
        logic [DEN_W:0]    t;
        logic              ge;

        if (s == 0) begin : g_first
            assign pv = in_valid;
            assign pa = '0;
            assign pq = in_num;
            assign ps = in_side;
        end else begin : g_next
            assign pv = v_reg[s-1];
            assign pa = a_reg[s-1];
            assign pq = q_reg[s-1];
            assign ps = s_reg[s-1];
        end

        assign rdy[s] = !v_reg[s] || rdy[s+1];
        assign t      = {pa, pq[NUM_W-1]};
        assign ge     = (t >= {1'b0, den});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (rdy[s])
            begin
                v_reg[s] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && pv)
            begin
                a_reg[s] <= ge ? DEN_W'(t - {1'b0, den}) : DEN_W'(t);
                q_reg[s] <= {pq[NUM_W-2:0], ge};
                s_reg[s] <= ps;
            end
        end
    end

    assign out_valid = v_reg[NUM_W-1];
    assign out_quo   = q_reg[NUM_W-1];
    assign out_rem   = a_reg[NUM_W-1];
    assign out_side  = s_reg[NUM_W-1];

endmodule

// ===== hdl/pgnl_axis.sv =====
`timescale 1ns / 1ps
// One axis: the five neighbour coordinates (offset -2..+2) with drop/wrap rule.
// Depends on pgnl_pkg.
module pgnl_axis #(
    parameter int CW = 11,
    parameter int SW = 11
) (
    input  logic [CW-1:0]                         coord,
    input  logic [SW-1:0]                         size,
    input  logic                                  wrap,
    output logic [pgnl_pkg::NUM_OFF-1:0]          ok,
    output logic [pgnl_pkg::NUM_OFF-1:0][CW-1:0]  coord_nb
);
    import pgnl_pkg::*;

    localparam int EW = (CW > SW ? CW : SW) + 2;

    always_comb
    begin
        logic [EW-1:0] s;
        logic [EW-1:0] sz;
        logic [EW-1:0] val;
        logic          neg;
        logic          oob;
        for (int d = 0; d < NUM_OFF; d++)
        begin
            sz  = EW'(size);
            s   = EW'(coord) + EW'(d) - EW'(OFF_CENTER);
            neg = s[EW-1];
            oob = neg || (s >= sz);
            if (!oob)
                val = s;
            else if (size == SW'(1))
                val = '0;
            else if (neg)
                val = s + sz;
            else
                val = s - sz;
            ok[d]       = !oob || wrap;
            coord_nb[d] = CW'(val);
        end
    end

endmodule

// ===== hdl/pgnl_geom.sv =====
`timescale 1ns / 1ps
// Two-stage geometry: neighbour coordinates per axis, then plane/row products
// and the 32-bit candidate mask. Depends on pgnl_pkg and pgnl_axis.
module pgnl_geom #(
    parameter int SW = 11,
    parameter int PW = 22
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic [SW-1:0]                                   x,
    input  logic [SW-1:0]                                   y,
    input  logic [pgnl_pkg::ID_W-1:0]                       z,
    input  logic                                            final_in,
    input  logic [SW-1:0]                                   size_x,
    input  logic [SW-1:0]                                   size_y,
    input  logic [SW-1:0]                                   size_z,
    input  logic                                            wrap_x,
    input  logic                                            wrap_y,
    input  logic                                            wrap_z,
    input  logic [PW-1:0]                                   plane,
    output logic                                            out_valid,
    input  logic                                            out_ready,
    output logic [pgnl_pkg::NUM_OFF-1:0][pgnl_pkg::ID_W-1:0] zterm,
    output logic [pgnl_pkg::NUM_OFF-1:0][pgnl_pkg::ID_W-1:0] yterm,
    output logic [pgnl_pkg::NUM_OFF-1:0][pgnl_pkg::ID_W-1:0] xterm,
    output logic [pgnl_pkg::NUM_CAND-1:0]                   mask,
    output logic                                            final_out
);
    import pgnl_pkg::*;

    logic [NUM_OFF-1:0]           okx_c, oky_c, okz_c;
    logic [NUM_OFF-1:0][SW-1:0]   nx_c, ny_c;
    logic [NUM_OFF-1:0][ID_W-1:0] nz_c;

    logic                         va_reg;
    logic [NUM_OFF-1:0]           okx_reg, oky_reg, okz_reg;
    logic [NUM_OFF-1:0][SW-1:0]   nx_reg, ny_reg;
    logic [NUM_OFF-1:0][ID_W-1:0] nz_reg;
    logic                         fa_reg;

    logic                         vb_reg;
    logic [NUM_OFF-1:0][ID_W-1:0] zt_reg, yt_reg, xt_reg;
    logic [NUM_CAND-1:0]          mask_reg;
    logic                         fb_reg;

    logic [NUM_OFF-1:0][ID_W-1:0] zt_next, yt_next, xt_next;
    logic [NUM_CAND-1:0]          mask_next;
    logic                         rdy_a, rdy_b;

    pgnl_axis #(.CW(SW), .SW(SW)) u_axis_x (
        .coord(x), .size(size_x), .wrap(wrap_x), .ok(okx_c), .coord_nb(nx_c)
    );
    pgnl_axis #(.CW(SW), .SW(SW)) u_axis_y (
        .coord(y), .size(size_y), .wrap(wrap_y), .ok(oky_c), .coord_nb(ny_c)
    );
    pgnl_axis #(.CW(ID_W), .SW(SW)) u_axis_z (
        .coord(z), .size(size_z), .wrap(wrap_z), .ok(okz_c), .coord_nb(nz_c)
    );

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb
    begin
        for (int d = 0; d < NUM_OFF; d++)
        begin
            zt_next[d] = nz_reg[d] * ID_W'(plane);
            yt_next[d] = ID_W'(ny_reg[d]) * ID_W'(size_x);
            xt_next[d] = ID_W'(nx_reg[d]);
        end
    end

    for (genvar p = 0; p < NUM_CAND; p++) begin : g_mask
        localparam off_t O = cand_off(p);
        assign mask_next[p] = okx_reg[O.ix] & oky_reg[O.iy] & okz_reg[O.iz];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                va_reg <= in_valid;
            if (rdy_b)
                vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            okx_reg <= okx_c;
            oky_reg <= oky_c;
            okz_reg <= okz_c;
            nx_reg  <= nx_c;
            ny_reg  <= ny_c;
            nz_reg  <= nz_c;
            fa_reg  <= final_in;
        end
        if (rdy_b && va_reg)
        begin
            zt_reg   <= zt_next;
            yt_reg   <= yt_next;
            xt_reg   <= xt_next;
            mask_reg <= mask_next;
            fb_reg   <= fa_reg;
        end
    end

    assign out_valid = vb_reg;
    assign zterm     = zt_reg;
    assign yterm     = yt_reg;
    assign xterm     = xt_reg;
    assign mask      = mask_reg;
    assign final_out = fb_reg;

endmodule

// ===== hdl/pgnl_emit.sv =====
`timescale 1ns / 1ps
// Result sequencer: walks the candidate mask lowest bit first, one beat per cycle
// while not stalled, into an output register. Depends on pgnl_pkg and pgnl_result_if.
module pgnl_emit (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic [pgnl_pkg::NUM_OFF-1:0][pgnl_pkg::ID_W-1:0] zterm,
    input  logic [pgnl_pkg::NUM_OFF-1:0][pgnl_pkg::ID_W-1:0] yterm,
    input  logic [pgnl_pkg::NUM_OFF-1:0][pgnl_pkg::ID_W-1:0] xterm,
    input  logic [pgnl_pkg::NUM_CAND-1:0]                   mask,
    input  logic                                            final_in,
    pgnl_result_if.source                                   result
);
    import pgnl_pkg::*;

    logic [NUM_CAND-1:0]          mask_reg;
    logic [NUM_OFF-1:0][ID_W-1:0] zt_reg, yt_reg, xt_reg;
    logic                         final_reg;

    logic                         ov_reg;
    logic [ID_W-1:0]              idx_reg;
    logic [KIND_W-1:0]            kind_reg;
    logic                         cd_reg;
    logic                         ld_reg;

    logic [NUM_CAND-1:0]          pick, rest;
    logic                         adv, emit, load;
    logic [NUM_CAND-1:0][OFF_W-1:0]  ix_t, iy_t, iz_t;
    logic [NUM_CAND-1:0][KIND_W-1:0] kind_t;
    logic [OFF_W-1:0]             ix_sel, iy_sel, iz_sel;
    logic [KIND_W-1:0]            kind_sel;
    logic [ID_W-1:0]              idx_next;

    assign adv      = !ov_reg || result.ready;
    assign pick     = mask_reg & (~mask_reg + NUM_CAND'(1));
    assign rest     = mask_reg & ~pick;
    assign emit     = (mask_reg != '0) && adv;
    assign in_ready = (mask_reg == '0) || (emit && rest == '0);
    assign load     = in_valid && in_ready;

    for (genvar p = 0; p < NUM_CAND; p++) begin : g_cand
        localparam off_t             O = cand_off(p);
        localparam logic [KIND_W-1:0] K = cand_kind(p);
        assign ix_t[p]   = pick[p] ? O.ix : '0;
        assign iy_t[p]   = pick[p] ? O.iy : '0;
        assign iz_t[p]   = pick[p] ? O.iz : '0;
        assign kind_t[p] = pick[p] ? K : '0;
    end

    always_comb
    begin
        ix_sel   = '0;
        iy_sel   = '0;
        iz_sel   = '0;
        kind_sel = '0;
        for (int p = 0; p < NUM_CAND; p++)
        begin
            ix_sel   = ix_sel | ix_t[p];
            iy_sel   = iy_sel | iy_t[p];
            iz_sel   = iz_sel | iz_t[p];
            kind_sel = kind_sel | kind_t[p];
        end
        idx_next = zt_reg[iz_sel] + yt_reg[iy_sel] + xt_reg[ix_sel];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (load)
                mask_reg <= mask;
            else if (emit)
                mask_reg <= rest;
            if (emit)
                ov_reg <= 1'b1;
            else if (result.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            zt_reg    <= zterm;
            yt_reg    <= yterm;
            xt_reg    <= xterm;
            final_reg <= final_in;
        end
        if (emit)
        begin
            idx_reg  <= idx_next;
            kind_reg <= kind_sel;
            cd_reg   <= (rest == '0);
            ld_reg   <= (rest == '0) && final_reg;
        end
    end

    assign result.valid           = ov_reg;
    assign result.neighbour_index = idx_reg;
    assign result.neighbour_kind  = kind_reg;
    assign result.cell_done       = cd_reg;
    assign result.list_done       = ld_reg;

    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        mask_reg != '0 |-> $onehot(pick))
        else $error("candidate pick is not one-hot");

    a_mask_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mask_reg != '0 && !adv |=> $stable(mask_reg))
        else $error("candidate mask moved while output stalled");

    a_list_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && ld_reg |-> cd_reg)
        else $error("list_done beat without cell_done");

endmodule

// ===== hdl/periodic_grid_neighbour_lister_top.sv =====
`timescale 1ns / 1ps
// Grid neighbour lister top level: config registers, two dividers, geometry
// and sequencer. Depends on pgnl_pkg, pgnl_if, pgnl_div, pgnl_geom, pgnl_emit.
//
// Usage:
//   query  (sink):   one beat per cell id with its final_query flag.
//   result (source): one beat per existing neighbour, cell_done on the last
//                    beat of a cell, list_done on that beat when final_query.
//   cfg:             cfg_wen/cfg_index/cfg_wdata write sizes and wrap bits;
//                    write only while no query is in flight.
// Path: a query passes the plane divider, the row divider, the geometry stages,
//   the sequencer's mask register and its output register.
// Throughput: one result beat per cycle while result.ready is high, set by the
//   sequencer's single output register; it takes the next cell with the last
//   beat of the current one, at once if it has none. The divider and geometry
//   stages take a query every cycle unless backed up, even while the sequencer is busy.
// Reset: all pipeline stages empty, sizes 1, wrap bits 0.
// Stall: when result.ready is low the output beat holds, the sequencer waits,
//   and the stages back up in turn until query.ready drops; nothing is lost.
module periodic_grid_neighbour_lister_top #(
    parameter int AXIS_MAX_CELLS = pgnl_pkg::AXIS_MAX_CELLS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [pgnl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pgnl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    pgnl_query_if.sink                        query,
    pgnl_result_if.source                     result
);
    import pgnl_pkg::*;

    localparam int SW = $clog2(AXIS_MAX_CELLS + 1);
    localparam int PW = 2 * SW;

    logic [SW-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [SW-1:0] size_x_next, size_y_next, size_z_next;
    logic          wrap_x_reg, wrap_y_reg, wrap_z_reg;
    logic          wrap_x_next, wrap_y_next, wrap_z_next;
    logic [PW-1:0] plane_reg, plane_next;

    function automatic logic [SW-1:0] clamp_size(input logic [CFG_DATA_W-1:0] v);
        if (v == '0)
            return SW'(1);
        else if (int'(v) > AXIS_MAX_CELLS)
            return SW'(AXIS_MAX_CELLS);
        else
            return SW'(v);
    endfunction

    always_comb
    begin
        size_x_next = size_x_reg;
        size_y_next = size_y_reg;
        size_z_next = size_z_reg;
        wrap_x_next = wrap_x_reg;
        wrap_y_next = wrap_y_reg;
        wrap_z_next = wrap_z_reg;
        if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SIZE_X: size_x_next = clamp_size(cfg_wdata);
                REG_SIZE_Y: size_y_next = clamp_size(cfg_wdata);
                REG_SIZE_Z: size_z_next = clamp_size(cfg_wdata);
                REG_WRAP_X: wrap_x_next = cfg_wdata[0];
                REG_WRAP_Y: wrap_y_next = cfg_wdata[0];
                REG_WRAP_Z: wrap_z_next = cfg_wdata[0];
                default: ;
            endcase
        end
        plane_next = PW'(size_x_next) * PW'(size_y_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SW'(1);
            size_y_reg <= SW'(1);
            size_z_reg <= SW'(1);
            wrap_x_reg <= 1'b0;
            wrap_y_reg <= 1'b0;
            wrap_z_reg <= 1'b0;
            plane_reg  <= PW'(1);
        end
        else
        begin
            size_x_reg <= size_x_next;
            size_y_reg <= size_y_next;
            size_z_reg <= size_z_next;
            wrap_x_reg <= wrap_x_next;
            wrap_y_reg <= wrap_y_next;
            wrap_z_reg <= wrap_z_next;
            plane_reg  <= plane_next;
        end
    end

    // id / plane -> z, remainder
    logic            d1_valid, d1_ready;
    logic [ID_W-1:0] d1_quo;
    logic [PW-1:0]   d1_rem;
    logic            d1_final;

    pgnl_div #(.NUM_W(ID_W), .DEN_W(PW), .SIDE_W(1)) u_div_plane (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (query.valid),
        .in_ready (query.ready),
        .in_num   (query.cell_index),
        .in_side  (query.final_query),
        .den      (plane_reg),
        .out_valid(d1_valid),
        .out_ready(d1_ready),
        .out_quo  (d1_quo),
        .out_rem  (d1_rem),
        .out_side (d1_final)
    );

    // remainder / size_x -> y, x
    logic            d2_valid, d2_ready;
    logic [PW-1:0]   d2_quo;
    logic [SW-1:0]   d2_rem;
    logic [ID_W:0]   d2_side;

    pgnl_div #(.NUM_W(PW), .DEN_W(SW), .SIDE_W(ID_W + 1)) u_div_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d1_valid),
        .in_ready (d1_ready),
        .in_num   (d1_rem),
        .in_side  ({d1_final, d1_quo}),
        .den      (size_x_reg),
        .out_valid(d2_valid),
        .out_ready(d2_ready),
        .out_quo  (d2_quo),
        .out_rem  (d2_rem),
        .out_side (d2_side)
    );

    logic                         g_valid, g_ready;
    logic [NUM_OFF-1:0][ID_W-1:0] g_zterm, g_yterm, g_xterm;
    logic [NUM_CAND-1:0]          g_mask;
    logic                         g_final;

    pgnl_geom #(.SW(SW), .PW(PW)) u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d2_valid),
        .in_ready (d2_ready),
        .x        (d2_rem),
        .y        (SW'(d2_quo)),
        .z        (d2_side[ID_W-1:0]),
        .final_in (d2_side[ID_W]),
        .size_x   (size_x_reg),
        .size_y   (size_y_reg),
        .size_z   (size_z_reg),
        .wrap_x   (wrap_x_reg),
        .wrap_y   (wrap_y_reg),
        .wrap_z   (wrap_z_reg),
        .plane    (plane_reg),
        .out_valid(g_valid),
        .out_ready(g_ready),
        .zterm    (g_zterm),
        .yterm    (g_yterm),
        .xterm    (g_xterm),
        .mask     (g_mask),
        .final_out(g_final)
    );

    pgnl_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (g_valid),
        .in_ready (g_ready),
        .zterm    (g_zterm),
        .yterm    (g_yterm),
        .xterm    (g_xterm),
        .mask     (g_mask),
        .final_in (g_final),
        .result   (result)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the periodic grid neighbour lister: queued cell queries
// against a local neighbour predictor, random gaps on both channels.
// Depends on pgnl_pkg, pgnl_if and periodic_grid_neighbour_lister_top.
module tb_top;
    import pgnl_pkg::*;

    localparam int     CLK_HALF     = 4;
    localparam longint RUN_LIMIT    = 1000000;
    localparam int     DRAIN_CYCLES = 120;
    localparam longint ID_MASK      = (64'd1 << ID_W) - 1;
    localparam int     RAND_PHASES  = 8;
    localparam int     PHASE_CELLS  = 50;

    typedef struct {
        logic [ID_W-1:0] cell_id;
        logic            last;
    } cell_req_t;

    typedef struct packed {
        logic [ID_W-1:0]   index;
        logic [KIND_W-1:0] kind;
        logic              cell_done;
        logic              list_done;
    } neighbour_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    pgnl_query_if  query ();
    pgnl_result_if result ();

    periodic_grid_neighbour_lister_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .query     (query),
        .result    (result)
    );

    cell_req_t  pending_cells[$];
    neighbour_t expected_neighbours[$];

    int     cells_x     = 1;
    int     cells_y     = 1;
    int     cells_z     = 1;
    bit     axis_wrap_x = 0;
    bit     axis_wrap_y = 0;
    bit     axis_wrap_z = 0;
    int     err_cnt     = 0;
    int     queued_cnt  = 0;
    int     taken_cnt   = 0;
    longint cycle_cnt   = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > RUN_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int clamp_cells(input logic [CFG_DATA_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > AXIS_MAX_CELLS_DEF)
            return AXIS_MAX_CELLS_DEF;
        return int'(v);
    endfunction

    // one axis step; 0 when the neighbour falls off a non-periodic axis
    function automatic bit step_axis(input longint c, input int d, input longint n_cells,
                                     input bit wrap, output longint moved);
        moved = c + d;
        if (moved < 0 || moved >= n_cells)
        begin
            if (!wrap)
                return 1'b0;
            if (n_cells == 1)
                moved = 0;
            else if (moved < 0)
                moved = moved + n_cells;
            else
                moved = moved - n_cells;
        end
        return 1'b1;
    endfunction

    task automatic list_neighbours(input logic [ID_W-1:0] cell_id, input logic last);
        longint     plane;
        longint     rem;
        longint     x;
        longint     y;
        longint     z;
        longint     nx;
        longint     ny;
        longint     nz;
        int         dx[NUM_CAND];
        int         dy[NUM_CAND];
        int         dz[NUM_CAND];
        neighbour_t found[NUM_CAND];
        int         n;
        int         hits;
        plane = longint'(cells_x) * cells_y;
        z     = longint'(cell_id) / plane;
        rem   = longint'(cell_id) % plane;
        y     = rem / cells_x;
        x     = rem % cells_x;
        n     = 0;
        for (int a = -1; a <= 1; a++)
            for (int b = -1; b <= 1; b++)
                for (int c = -1; c <= 1; c++)
                    if (a != 0 || b != 0 || c != 0)
                    begin
                        dx[n] = a;
                        dy[n] = b;
                        dz[n] = c;
                        n++;
                    end
        // axial distance-2 cells: -x, -y, -z, +x, +y, +z
        for (int k = 0; k < 6; k++)
        begin
            dx[n] = (k == 0) ? -2 : (k == 3) ? 2 : 0;
            dy[n] = (k == 1) ? -2 : (k == 4) ? 2 : 0;
            dz[n] = (k == 2) ? -2 : (k == 5) ? 2 : 0;
            n++;
        end
        hits = 0;
        for (int p = 0; p < NUM_CAND; p++)
        begin
            if (step_axis(x, dx[p], cells_x, axis_wrap_x, nx) &&
                step_axis(y, dy[p], cells_y, axis_wrap_y, ny) &&
                step_axis(z, dz[p], cells_z, axis_wrap_z, nz))
            begin
                found[hits].index = ID_W'((nz * cells_y * cells_x + ny * cells_x + nx)
                                          & ID_MASK);
                found[hits].kind  = KIND_W'((dz[p] + OFF_CENTER) * KIND_Z_STRIDE
                                            + (dy[p] + OFF_CENTER) * KIND_Y_STRIDE
                                            + (dx[p] + OFF_CENTER));
                found[hits].cell_done = 1'b0;
                found[hits].list_done = 1'b0;
                hits++;
            end
        end
        if (hits > 0)
        begin
            found[hits-1].cell_done = 1'b1;
            found[hits-1].list_done = last;
        end
        for (int p = 0; p < hits; p++)
            expected_neighbours.push_back(found[p]);
    endtask

    // idle with a 7 percent chance, except in a quiet window that recurs in each period of the cycle counter
    function automatic bit take_gap();
        return (cycle_cnt % 3000 >= 800) && ($urandom_range(99) < 7);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_cnt++;
        if (err_cnt <= 30)
            $display("MISMATCH t=%0t %s: got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_query
        cell_req_t nxt;
        if (!rst_n)
        begin
            query.valid       <= 1'b0;
            query.cell_index  <= '0;
            query.final_query <= 1'b0;
        end
        else
        begin
            if (query.valid && query.ready)
            begin
                list_neighbours(query.cell_index, query.final_query);
                taken_cnt++;
            end
            if (!query.valid || query.ready)
            begin
                if (pending_cells.size() > 0 && !take_gap())
                begin
                    nxt = pending_cells.pop_front();
                    query.valid       <= 1'b1;
                    query.cell_index  <= nxt.cell_id;
                    query.final_query <= nxt.last;
                end
                else
                begin
                    query.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_result
        neighbour_t want;
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_neighbours.size() == 0)
                begin
                    report_mismatch("beat with nothing pending, neighbour_index",
                                    result.neighbour_index, -1);
                end
                else
                begin
                    want = expected_neighbours.pop_front();
                    if (result.neighbour_index !== want.index)
                        report_mismatch("neighbour_index", result.neighbour_index, want.index);
                    if (result.neighbour_kind !== want.kind)
                        report_mismatch("neighbour_kind", result.neighbour_kind, want.kind);
                    if (result.cell_done !== want.cell_done)
                        report_mismatch("cell_done", result.cell_done, want.cell_done);
                    if (result.list_done !== want.list_done)
                        report_mismatch("list_done", result.list_done, want.list_done);
                end
            end
            result.ready <= !take_gap();
        end
    end

    task automatic cfg_write(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        case (r)
            REG_SIZE_X: cells_x     = clamp_cells(v);
            REG_SIZE_Y: cells_y     = clamp_cells(v);
            REG_SIZE_Z: cells_z     = clamp_cells(v);
            REG_WRAP_X: axis_wrap_x = v[0];
            REG_WRAP_Y: axis_wrap_y = v[0];
            REG_WRAP_Z: axis_wrap_z = v[0];
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [CFG_DATA_W-1:0] sx, input logic [CFG_DATA_W-1:0] sy,
                            input logic [CFG_DATA_W-1:0] sz, input logic [CFG_DATA_W-1:0] wx,
                            input logic [CFG_DATA_W-1:0] wy, input logic [CFG_DATA_W-1:0] wz);
        cfg_write(REG_SIZE_X, sx);
        cfg_write(REG_SIZE_Y, sy);
        cfg_write(REG_SIZE_Z, sz);
        cfg_write(REG_WRAP_X, wx);
        cfg_write(REG_WRAP_Y, wy);
        cfg_write(REG_WRAP_Z, wz);
    endtask

    task automatic queue_cell(input logic [ID_W-1:0] cell_id, input logic last);
        cell_req_t req;
        req.cell_id = cell_id;
        req.last    = last;
        pending_cells.push_back(req);
        queued_cnt++;
    endtask

    // all queries taken, all results seen, then room for cells with no results
    task automatic wait_idle();
        while (taken_cnt != queued_cnt || expected_neighbours.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic longint edge_coord(input int n);
        case ($urandom_range(3))
            0:       return 0;
            1:       return n - 1;
            default: return $urandom_range(n - 1);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_cell();
        longint id;
        if ($urandom_range(99) < 15)
            return ID_W'($urandom);
        if ($urandom_range(99) < 30)
        begin
            id = (longint'($urandom) << 8) % (longint'(cells_x) * cells_y * cells_z);
            return ID_W'(id);
        end
        id = edge_coord(cells_z) * cells_y * cells_x + edge_coord(cells_y) * cells_x
             + edge_coord(cells_x);
        return ID_W'(id);
    endfunction

    initial
    begin : stimulus
        query.valid       = 1'b0;
        query.cell_index  = '0;
        query.final_query = 1'b0;
        result.ready      = 1'b0;
        cfg_wen           = 1'b0;
        cfg_index         = REG_SIZE_X;
        cfg_wdata         = '0;
        rst_n             = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset grid is a single cell with no wrap: no neighbours at all
        queue_cell(30'd0, 1'b0);
        queue_cell(30'h3FFF_FFFF, 1'b1);
        queue_cell(30'h1555_5555, 1'b0);
        wait_idle();

        // 4x3x5, open; wrap registers written with junk in the upper bits
        set_grid(11'd4, 11'd3, 11'd5, 11'h7FE, 11'h2AA, 11'h554);
        queue_cell(30'd0, 1'b0);
        queue_cell(30'd29, 1'b0);
        queue_cell(30'd59, 1'b1);
        queue_cell(30'd60, 1'b0);
        queue_cell(30'h3FFF_FFFF, 1'b1);
        queue_cell(30'd5, 1'b0);
        wait_idle();

        // same grid, fully periodic
        set_grid(11'd4, 11'd3, 11'd5, 11'd1, 11'd1, 11'd1);
        queue_cell(30'd0, 1'b1);
        queue_cell(30'd59, 1'b0);
        queue_cell(30'd17, 1'b0);
        queue_cell(30'd75, 1'b1);
        wait_idle();

        // zero size acts as one; periodic axes of size one and two
        set_grid(11'd0, 11'd2, 11'd1, 11'h001, 11'h7FF, 11'h401);
        queue_cell(30'd0, 1'b0);
        queue_cell(30'd1, 1'b1);
        queue_cell(30'd5, 1'b0);
        wait_idle();

        // oversized x saturates, largest grid
        set_grid(11'd2047, 11'd1024, 11'd1024, 11'd1, 11'd0, 11'd1);
        queue_cell(30'd0, 1'b0);
        queue_cell(30'h3FFF_FFFF, 1'b1);
        queue_cell(30'h2AAA_AAAA, 1'b0);
        wait_idle();

        // cells beyond the grid on a periodic z axis
        set_grid(11'd1025, 11'd7, 11'd3, 11'd0, 11'd0, 11'd1);
        queue_cell(30'd0, 1'b0);
        queue_cell(30'd21503, 1'b0);
        queue_cell(30'd21504, 1'b1);
        queue_cell(30'd50176, 1'b0);
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            set_grid(($urandom_range(3) == 0) ? 11'($urandom_range(2047)) : 11'($urandom_range(8)),
                     ($urandom_range(3) == 0) ? 11'($urandom_range(2047)) : 11'($urandom_range(8)),
                     ($urandom_range(3) == 0) ? 11'($urandom_range(2047)) : 11'($urandom_range(8)),
                     11'($urandom_range(2047)), 11'($urandom_range(2047)),
                     11'($urandom_range(2047)));
            for (int i = 0; i < PHASE_CELLS; i++)
                queue_cell(pick_cell(), $urandom_range(7) == 0);
            wait_idle();
        end

        if (err_cnt == 0 && expected_neighbours.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pgnl_pkg.sv
hdl/pgnl_if.sv
hdl/pgnl_div.sv
hdl/pgnl_axis.sv
hdl/pgnl_geom.sv
hdl/pgnl_emit.sv
hdl/periodic_grid_neighbour_lister_top.sv
dv/tb_top.sv
